// ===== hw/rtl/ssd_pkg.sv =====
package ssd_pkg;

    // Number of multiplexed digits and the width of a digit index.
    localparam int unsigned DIGIT_COUNT = 4;
    localparam int unsigned POS_W       = 2;

    // Field widths.
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned SEC_W   = 16;

    // Configuration address width and the byte address of the seconds limit.
    localparam int unsigned        ADDR_W                = 3;
    localparam logic [ADDR_W-1:0]  ADDR_TICKS_PER_SECOND = 3'd0;

    // The decimal point sits at segment bit 5.
    localparam logic [SEG_W-1:0] DOT_MASK   = 8'h20;
    localparam logic [SEG_W-1:0] SEG_ALLOFF = 8'hFF;

    // Reset value of the seconds limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1000;

    // Character codes that are not hex digits.
    localparam logic [7:0] CHAR_BLANK = 8'd16;
    localparam logic [7:0] CHAR_MINUS = 8'd17;

    // Item kinds carried in the input tuser.
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_RAW  = 2'd1,
        MODE_CHAR = 2'd2,
        MODE_DOT  = 2'd3
    } t_mode;

    // Active-low glyph for a character code, decimal point bit left clear.
    // Codes beyond the minus sign show as blank.
    function automatic logic [SEG_W-1:0] glyph(input logic [7:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            8'd0:       seg = 8'h08;
            8'd1:       seg = 8'hCB;
            8'd2:       seg = 8'h12;
            8'd3:       seg = 8'h82;
            8'd4:       seg = 8'hC1;
            8'd5:       seg = 8'h84;
            8'd6:       seg = 8'h04;
            8'd7:       seg = 8'hCA;
            8'd8:       seg = 8'h00;
            8'd9:       seg = 8'h80;
            8'd10:      seg = 8'h40;
            8'd11:      seg = 8'h05;
            8'd12:      seg = 8'h1C;
            8'd13:      seg = 8'h03;
            8'd14:      seg = 8'h14;
            8'd15:      seg = 8'h54;
            CHAR_MINUS: seg = 8'hD7;
            default:    seg = 8'hDF;
        endcase
        return seg;
    endfunction

endpackage

// ===== hw/rtl/seven_segment_scan_driver_core.sv =====
// Each accepted transaction's result appears on the master side in the next cycle.
// One transaction per cycle when not stalled; the output register frees when taken.
// All work for an item is a single combinational pass into the result register.
// Reset (synchronous, active low) blanks every digit, clears the scan position
// and both counters, and loads the seconds limit with 1000.
module seven_segment_scan_driver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] position, [9:2] value, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] segments, [9:8] digit_select,
                                        // [25:10] seconds_count, rest zero
    output logic        m_axis_tuser,   // [0] scan_valid
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ssd_pkg::t_mode                       in_mode;
    logic [ssd_pkg::POS_W-1:0]            in_pos;
    logic [7:0]                           in_value;
    logic                                 in_fire;
    logic                                 tick;

    logic [ssd_pkg::SEG_W-1:0]            r_digits [ssd_pkg::DIGIT_COUNT];
    logic [ssd_pkg::SEG_W-1:0]            n_digit;
    logic                                 digit_we;
    logic [ssd_pkg::POS_W-1:0]            r_scan_pos;
    logic [ssd_pkg::POS_W-1:0]            n_scan_pos;
    logic [ssd_pkg::LIMIT_W-1:0]          r_limit;
    logic [ssd_pkg::SEC_W-1:0]            seconds_next;

    logic                                 r_out_valid;
    logic                                 r_out_scan;
    logic [ssd_pkg::SEG_W-1:0]            r_out_seg;
    logic [ssd_pkg::POS_W-1:0]            r_out_sel;
    logic [ssd_pkg::SEC_W-1:0]            r_out_sec;

    // Unpack the input transaction.
    assign in_mode  = ssd_pkg::t_mode'(s_axis_tuser);
    assign in_pos   = s_axis_tdata[1:0];
    assign in_value = s_axis_tdata[9:2];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign tick     = in_fire && (in_mode == ssd_pkg::MODE_TICK);

    // Configuration register: single write port; its address reads back the limit.
    assign pready = 1'b1;
    assign prdata = (paddr == ssd_pkg::ADDR_TICKS_PER_SECOND) ? {22'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ssd_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == ssd_pkg::ADDR_TICKS_PER_SECOND) begin
            r_limit <= pwdata[ssd_pkg::LIMIT_W-1:0];
        end
    end

    // New contents of the addressed digit for the three write kinds.
    always_comb begin
        n_digit  = r_digits[in_pos];
        digit_we = in_fire && (in_mode != ssd_pkg::MODE_TICK)
                   && (32'(in_pos) < ssd_pkg::DIGIT_COUNT);
        unique case (in_mode)
            ssd_pkg::MODE_RAW:  n_digit = ~in_value;
            ssd_pkg::MODE_CHAR: n_digit = (r_digits[in_pos] & ssd_pkg::DOT_MASK)
                                          | ssd_pkg::glyph(in_value);
            ssd_pkg::MODE_DOT:  n_digit = (in_value != 8'd0)
                                          ? (r_digits[in_pos] & ~ssd_pkg::DOT_MASK)
                                          : (r_digits[in_pos] | ssd_pkg::DOT_MASK);
            default:            n_digit = r_digits[in_pos];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssd_pkg::DIGIT_COUNT; i++) begin
                r_digits[i] <= ssd_pkg::SEG_ALLOFF;
            end
        end else if (digit_we) begin
            r_digits[in_pos] <= n_digit;
        end
    end

    // Scan position steps round the digits on every tick.
    always_comb begin
        if (32'(r_scan_pos) >= ssd_pkg::DIGIT_COUNT - 1) begin
            n_scan_pos = '0;
        end else begin
            n_scan_pos = r_scan_pos + ssd_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos <= '0;
        end else if (tick) begin
            r_scan_pos <= n_scan_pos;
        end
    end

    // Millisecond and seconds counting.
    ssd_timebase u_timebase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (tick),
        .i_limit        (r_limit),
        .o_seconds_next (seconds_next)
    );

    // Result register: loaded on every accepted transaction, held while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_scan <= tick;
            r_out_seg  <= tick ? r_digits[r_scan_pos] : '0;
            r_out_sel  <= tick ? r_scan_pos : '0;
            r_out_sec  <= seconds_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_scan;
    assign m_axis_tdata  = {6'd0, r_out_sec, r_out_sel, r_out_seg};

    // A tick always produces a scanned digit in the next result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick |=> (r_out_valid && r_out_scan))
        else $error("tick did not produce a scan result");

    // A write result drives no segments and no digit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !tick) |=> (!r_out_scan && r_out_seg == '0 && r_out_sel == '0))
        else $error("write result carried scan data");

    // The scan position moves only on a tick.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick |=> $stable(r_scan_pos))
        else $error("scan position moved without a tick");

    // A write result reports the seconds count as it stood when it was accepted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !tick) |=> (r_out_sec == $past(seconds_next)))
        else $error("write result seconds count wrong");

endmodule

// ===== hw/rtl/ssd_timebase.sv =====
module ssd_timebase (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tick,
    input  logic [ssd_pkg::LIMIT_W-1:0]      i_limit,
    output logic [ssd_pkg::SEC_W-1:0]        o_seconds_next
);

    logic [ssd_pkg::LIMIT_W-1:0] r_ms;
    logic [ssd_pkg::LIMIT_W-1:0] n_ms;
    logic [ssd_pkg::SEC_W-1:0]   r_sec;
    logic [ssd_pkg::SEC_W-1:0]   n_sec;

    // On a tick the millisecond count restarts at one once it has reached the
    // limit, and the seconds count steps on; otherwise it simply counts up.
    always_comb begin
        n_ms  = r_ms;
        n_sec = r_sec;
        if (i_tick) begin
            if (r_ms >= i_limit) begin
                n_ms  = ssd_pkg::LIMIT_W'(1);
                n_sec = r_sec + ssd_pkg::SEC_W'(1);
            end else begin
                n_ms = r_ms + ssd_pkg::LIMIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms  <= '0;
            r_sec <= '0;
        end else begin
            r_ms  <= n_ms;
            r_sec <= n_sec;
        end
    end

    // The result of an item carries the count as it stands after that item.
    assign o_seconds_next = n_sec;

endmodule

// ===== tb/sv/seven_segment_scan_driver_core_tb.sv =====
module seven_segment_scan_driver_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Run control.
    localparam int unsigned CYCLE_LIMIT      = 900_000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 8;

    // One result transaction as seen on the master side.
    typedef struct packed {
        logic                       scan_valid;
        logic [ssd_pkg::SEG_W-1:0]  segments;
        logic [ssd_pkg::POS_W-1:0]  digit_select;
        logic [ssd_pkg::SEC_W-1:0]  seconds;
    } t_scan_result;

    // One row of the directed stimulus; typed rows carry their own result.
    typedef struct packed {
        ssd_pkg::t_mode mode;
        logic [1:0]     pos;
        logic [7:0]     value;
        logic           typed;
        t_scan_result   want;
    } t_dir_row;

    localparam t_scan_result WRITE_ACK = '{1'b0, 8'h00, 2'd0, 16'd0};

    // Active-low glyphs for hex digits, blank and minus, decimal point bit left clear.
    localparam logic [7:0] SEGMENT_FONT [18] = '{
        8'h08, 8'hCB, 8'h12, 8'h82, 8'hC1, 8'h84, 8'h04, 8'hCA,
        8'h00, 8'h80, 8'h40, 8'h05, 8'h1C, 8'h03, 8'h14, 8'h54,
        8'hDF, 8'hD7
    };

    // Directed part: ticks from reset, every write kind, font edges, dot handling.
    localparam int unsigned DIRECTED_COUNT = 24;
    localparam t_dir_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{ssd_pkg::MODE_TICK, 2'd0, 8'h00, 1'b1, '{1'b1, 8'hFF, 2'd0, 16'd0}},
        '{ssd_pkg::MODE_TICK, 2'd3, 8'hFF, 1'b1, '{1'b1, 8'hFF, 2'd1, 16'd0}},
        '{ssd_pkg::MODE_RAW,  2'd0, 8'h00, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_RAW,  2'd3, 8'hFF, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_RAW,  2'd1, 8'hAA, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_CHAR, 2'd1, 8'd0,  1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_CHAR, 2'd2, 8'd15, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_CHAR, 2'd0, 8'd17, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_CHAR, 2'd3, 8'd16, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_DOT,  2'd3, 8'h01, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_CHAR, 2'd3, 8'd18, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_DOT,  2'd2, 8'hFF, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_CHAR, 2'd2, 8'hFF, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_DOT,  2'd0, 8'h00, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_DOT,  2'd1, 8'h80, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_TICK, 2'd0, 8'h00, 1'b0, '0},
        '{ssd_pkg::MODE_TICK, 2'd1, 8'h55, 1'b0, '0},
        '{ssd_pkg::MODE_TICK, 2'd2, 8'hAA, 1'b0, '0},
        '{ssd_pkg::MODE_TICK, 2'd3, 8'h00, 1'b0, '0},
        '{ssd_pkg::MODE_RAW,  2'd2, 8'h55, 1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_CHAR, 2'd0, 8'd9,  1'b1, WRITE_ACK},
        '{ssd_pkg::MODE_TICK, 2'd0, 8'h00, 1'b0, '0},
        '{ssd_pkg::MODE_TICK, 2'd0, 8'h00, 1'b0, '0},
        '{ssd_pkg::MODE_TICK, 2'd0, 8'h00, 1'b0, '0}
    };

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [1:0] position, [9:2] value, rest zero
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] mode
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;         // [7:0] segments, [9:8] digit_select,
                                       // [25:10] seconds_count, rest zero
    wire         m_axis_tuser;         // [0] scan_valid
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    wire  [31:0] prdata;
    wire         pready;

    seven_segment_scan_driver_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow of the display state, updated as transactions are accepted.
    logic [ssd_pkg::SEG_W-1:0]   digit_bytes [ssd_pkg::DIGIT_COUNT];
    logic [ssd_pkg::POS_W-1:0]   scan_digit;
    logic [ssd_pkg::LIMIT_W-1:0] ms_count;
    logic [ssd_pkg::SEC_W-1:0]   sec_count;
    logic [ssd_pkg::LIMIT_W-1:0] seconds_limit;

    t_scan_result expected_scans [$];

    int unsigned error_count       = 0;
    int unsigned cycle_count       = 0;
    int unsigned idle_pct          = 0;
    int unsigned long_holds_asked  = 0;
    int unsigned long_holds_done   = 0;
    int unsigned hold_left         = 0;

    always #5 i_clk = ~i_clk;

    // Prints one line per mismatch and counts them all.
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        error_count++;
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // Applies one transaction to the shadow state and returns the result it causes.
    function automatic t_scan_result predict_display(input ssd_pkg::t_mode mode,
                                                     input logic [1:0] pos,
                                                     input logic [7:0] value);
        t_scan_result r;
        logic [ssd_pkg::POS_W-1:0] p;
        r = '0;
        case (mode)
            ssd_pkg::MODE_TICK: begin
                p = scan_digit;
                r.scan_valid   = 1'b1;
                r.segments     = digit_bytes[p];
                r.digit_select = p;
                scan_digit = (p == ssd_pkg::DIGIT_COUNT - 1) ? '0 : p + 1'b1;
                if (ms_count >= seconds_limit) begin
                    ms_count  = '0;
                    sec_count = sec_count + 1'b1;
                end
                ms_count = ms_count + 1'b1;
            end
            ssd_pkg::MODE_RAW: begin
                digit_bytes[pos] = ~value;
            end
            ssd_pkg::MODE_CHAR: begin
                // Codes past the minus sign fall back to blank; the dot is kept.
                digit_bytes[pos] = (digit_bytes[pos] & ssd_pkg::DOT_MASK)
                                 | SEGMENT_FONT[(value > ssd_pkg::CHAR_MINUS)
                                                ? ssd_pkg::CHAR_BLANK : value];
            end
            default: begin
                if (value != 8'd0)
                    digit_bytes[pos] = digit_bytes[pos] & ~ssd_pkg::DOT_MASK;
                else
                    digit_bytes[pos] = digit_bytes[pos] | ssd_pkg::DOT_MASK;
            end
        endcase
        r.seconds = sec_count;
        return r;
    endfunction

    // Offers one transaction, with an optional idle burst first, and records
    // its expected result once it has been accepted.
    task automatic push_item(input ssd_pkg::t_mode mode, input logic [1:0] pos,
                             input logic [7:0] value, input logic typed,
                             input t_scan_result typed_want);
        t_scan_result predicted;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, value, pos};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_display(mode, pos, value);
        expected_scans.push_back(typed ? typed_want : predicted);
    endtask

    // One APB transfer to the limit register: setup cycle, then access cycle.
    task automatic apb_transfer(input logic write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ssd_pkg::ADDR_TICKS_PER_SECOND;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes the limit, mirrors it in the shadow state and reads it back.
    task automatic set_seconds_limit(input logic [ssd_pkg::LIMIT_W-1:0] limit);
        logic [31:0] rd;
        apb_transfer(1'b1, 32'(limit), rd);
        seconds_limit = limit;
        apb_transfer(1'b0, '0, rd);
        if (rd !== 32'(seconds_limit))
            report_mismatch("limit readback", rd, seconds_limit);
    endtask

    task automatic wait_drained();
        while (expected_scans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A phase: settle, set the limit, then a stream of random transactions.
    task automatic run_phase(input logic [ssd_pkg::LIMIT_W-1:0] limit,
                             input int unsigned count, input int unsigned tick_pct,
                             input int unsigned idle, input logic with_long_hold);
        ssd_pkg::t_mode mode;
        logic [1:0]     pos;
        logic [7:0]     value;
        wait_drained();
        set_seconds_limit(limit);
        idle_pct = idle;
        if (with_long_hold)
            long_holds_asked++;
        repeat (count) begin
            mode = ($urandom_range(0, 99) < tick_pct)
                   ? ssd_pkg::MODE_TICK : ssd_pkg::t_mode'($urandom_range(1, 3));
            pos  = 2'($urandom_range(0, 3));
            case (mode)
                ssd_pkg::MODE_CHAR: value = ($urandom_range(0, 4) == 0)
                                            ? 8'($urandom_range(18, 255))
                                            : 8'($urandom_range(0, 17));
                ssd_pkg::MODE_DOT:  value = $urandom_range(0, 1)
                                            ? 8'd0 : 8'($urandom_range(1, 255));
                default:            value = 8'($urandom_range(0, 255));
            endcase
            push_item(mode, pos, value, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Result side: checks each accepted transaction and paces tready.
    always @(posedge i_clk) begin
        t_scan_result got;
        t_scan_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8], m_axis_tdata[25:10]};
            if (expected_scans.size() == 0) begin
                report_mismatch("unexpected result", got, 0);
            end else begin
                want = expected_scans.pop_front();
                if (got.scan_valid !== want.scan_valid)
                    report_mismatch("scan_valid", got.scan_valid, want.scan_valid);
                if (got.segments !== want.segments)
                    report_mismatch("segments", got.segments, want.segments);
                if (got.digit_select !== want.digit_select)
                    report_mismatch("digit_select", got.digit_select, want.digit_select);
                if (got.seconds !== want.seconds)
                    report_mismatch("seconds_count", got.seconds, want.seconds);
                if (m_axis_tdata[31:26] !== 6'b0)
                    report_mismatch("tdata padding", m_axis_tdata[31:26], 0);
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (long_holds_done != long_holds_asked) begin
            // Long back-pressure so that the block fills up and stalls its input.
            long_holds_done++;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 199) < idle_pct) begin
            hold_left = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [31:0] rd;
        t_dir_row    row;
        for (int d = 0; d < ssd_pkg::DIGIT_COUNT; d++)
            digit_bytes[d] = ssd_pkg::SEG_ALLOFF;
        scan_digit    = '0;
        ms_count      = '0;
        sec_count     = '0;
        seconds_limit = ssd_pkg::LIMIT_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The limit register must come out of reset at its documented value.
        apb_transfer(1'b0, '0, rd);
        if (rd !== 32'(ssd_pkg::LIMIT_RESET))
            report_mismatch("limit after reset", rd, ssd_pkg::LIMIT_RESET);

        // Directed part with the reset limit in place.
        idle_pct = 20;
        for (int n = 0; n < DIRECTED_COUNT; n++) begin
            row = DIRECTED_ROWS[n];
            push_item(row.mode, row.pos, row.value, row.typed, row.want);
        end
        s_axis_tvalid <= 1'b0;

        // Random phases across the limit range, extremes and a zero limit included.
        run_phase(10'd1,    200, 50, 20, 1'b0);
        run_phase(10'd1023, 300, 90, 10, 1'b1);
        run_phase(10'd0,    150, 50, 30, 1'b0);
        run_phase(10'($urandom_range(2, 40)), 150, 60, 5, 1'b1);
        // Last part: no idling and a zero limit, so seconds step on every tick.
        run_phase(10'd0,    376, 99, 0, 1'b0);

        wait_drained();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
